// File: hw/rtl/pda_pkg.sv
// Shared types, constants and arithmetic helpers for the pairwise direction angle pipeline.
package pda_pkg;

    localparam int IDX_W       = 9;
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = 33;
    localparam int POS_W       = 6;
    localparam int NORM_W      = 30;
    localparam int NORM_TOP    = 29;
    localparam int SQ_W        = 60;
    localparam int RAD_W       = 62;
    localparam int ROOT_W      = 31;
    localparam int REM_W       = 33;
    localparam int ROT_W       = 34;
    localparam int ANG_W       = 24;
    localparam int ATAN_W      = 21;
    localparam int STEP_W      = 5;
    localparam int ANGLE_W     = 16;
    localparam int SQRT_CELLS  = 31;
    localparam int CORDIC_STEPS = 20;

    localparam logic [ANGLE_W-1:0] PI_Q14             = 16'd51472;
    localparam logic [ANGLE_W-1:0] HALF_PI_APPROX_Q14 = 16'd25735;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q20   = 24'sd1647099;

    localparam logic [ATAN_W-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
        21'd823550, 21'd486170, 21'd256879, 21'd130396, 21'd65451,
        21'd32757,  21'd16383,  21'd8192,   21'd4096,   21'd2048,
        21'd1024,   21'd512,    21'd256,    21'd128,    21'd64,
        21'd32,     21'd16,     21'd8,      21'd4,      21'd2
    };

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             zero_out;
        logic             vert;
    } pda_id_t;

    typedef struct packed {
        pda_id_t           id;
        logic              az_neg;
        logic              po_neg;
        logic [NORM_W-1:0] az_x;
        logic [NORM_W-1:0] az_y;
        logic [NORM_W-1:0] pz;
    } pda_tag_t;

    typedef struct packed {
        pda_tag_t          tag;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } pda_sqrt_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } pda_rot_t;

    typedef struct packed {
        pda_id_t  id;
        pda_rot_t az;
        pda_rot_t po;
    } pda_cord_t;

    // position of the highest set bit, zero for a zero word
    function automatic logic [POS_W-1:0] top_bit(input logic [DIFF_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < DIFF_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    // shift so that a word whose top bit sits at p lands with its top bit at NORM_TOP
    function automatic logic [NORM_W-1:0] norm_val(input logic [DIFF_W-1:0] v,
                                                   input logic [POS_W-1:0] p);
        logic [DIFF_W-1:0] s;
        if (p > POS_W'(NORM_TOP)) begin
            s = v >> (p - POS_W'(NORM_TOP));
        end
        else begin
            s = v << (POS_W'(NORM_TOP) - p);
        end
        return s[NORM_W-1:0];
    endfunction

    // left half plane is turned by -pi/2 before vectoring
    function automatic pda_rot_t cordic_init(input logic neg, input logic [NORM_W-1:0] ax,
                                             input logic [NORM_W-1:0] ay);
        pda_rot_t r;
        if (neg) begin
            r.x = $signed({4'b0000, ay});
            r.y = $signed({4'b0000, ax});
            r.z = HALF_PI_Q20;
        end
        else begin
            r.x = $signed({4'b0000, ax});
            r.y = $signed({4'b0000, ay});
            r.z = '0;
        end
        return r;
    endfunction

    function automatic pda_rot_t cordic_step(input pda_rot_t r, input logic [STEP_W-1:0] i);
        pda_rot_t o;
        logic signed [ROT_W-1:0] xs;
        logic signed [ROT_W-1:0] ys;
        logic signed [ANG_W-1:0] a;
        xs = r.x >>> i;
        ys = r.y >>> i;
        a  = $signed({3'b000, ATAN_Q20[i]});
        if (r.y > 0) begin
            o.x = r.x + ys;
            o.y = r.y - xs;
            o.z = r.z + a;
        end
        else begin
            o.x = r.x - ys;
            o.y = r.y + xs;
            o.z = r.z - a;
        end
        return o;
    endfunction

    // Q.20 to Q2.14 with round half up, clamped to 0..pi
    function automatic logic [ANGLE_W-1:0] angle_round(input logic signed [ANG_W-1:0] z);
        logic [ANG_W-1:0] zc;
        logic [ANG_W-1:0] zr;
        logic [ANG_W-7:0] r;
        zc = z[ANG_W-1] ? '0 : $unsigned(z);
        zr = zc + ANG_W'(32);
        r  = zr[ANG_W-1:6];
        if (r > (ANG_W-6)'(PI_Q14)) begin
            return PI_Q14;
        end
        return r[ANGLE_W-1:0];
    endfunction

endpackage

// File: hw/rtl/pda_if.sv
// Handshake channels for particle pair words and angle result words.
interface pda_in_if;
    import pda_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;

    modport source (
        output valid, row_index, col_index, first_x, first_y, first_z,
               second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, row_index, col_index, first_x, first_y, first_z,
               second_x, second_y, second_z,
        output ready
    );
endinterface

interface pda_out_if;
    import pda_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   out_row;
    logic [IDX_W-1:0]   out_col;
    logic [ANGLE_W-1:0] azimuth;
    logic [ANGLE_W-1:0] polar;

    modport source (
        output valid, out_row, out_col, azimuth, polar,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_col, azimuth, polar,
        output ready
    );
endinterface

// File: hw/rtl/pda_front.sv
// Front cells: difference vector, normalization, squares and their sum.
module pda_front (
    input  logic                  clk,
    input  logic                  rst_n,
    pda_in_if.sink                pairs,
    output logic                  tag_valid,
    input  logic                  tag_ready,
    output pda_pkg::pda_tag_t     tag,
    output logic [pda_pkg::RAD_W-1:0] sq_sum
);
    import pda_pkg::*;

    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [DIFF_W-1:0] mx, my, mz, m_az, m_po;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: differences and magnitudes
    logic              v1_reg;
    pda_id_t           id1_reg;
    logic              azn1_reg, pon1_reg;
    logic [DIFF_W-1:0] nx1_reg, ny1_reg, nz1_reg;
    // stage 2: normalization positions
    logic              v2_reg;
    pda_id_t           id2_reg;
    logic              azn2_reg, pon2_reg;
    logic [DIFF_W-1:0] nx2_reg, ny2_reg, nz2_reg;
    logic [POS_W-1:0]  paz2_reg, ppo2_reg;
    // stage 3: shifted values
    logic              v3_reg;
    pda_tag_t          t3_reg;
    logic [NORM_W-1:0] px3_reg, py3_reg;
    // stage 4: squares
    logic              v4_reg;
    pda_tag_t          t4_reg;
    logic [SQ_W-1:0]   sx4_reg, sy4_reg;
    // stage 5: sum
    logic              v5_reg;
    pda_tag_t          t5_reg;
    logic [RAD_W-1:0]  sum5_reg;

    assign dx = $signed({pairs.second_x[COORD_W-1], pairs.second_x})
              - $signed({pairs.first_x[COORD_W-1], pairs.first_x});
    assign dy = $signed({pairs.second_y[COORD_W-1], pairs.second_y})
              - $signed({pairs.first_y[COORD_W-1], pairs.first_y});
    assign dz = $signed({pairs.second_z[COORD_W-1], pairs.second_z})
              - $signed({pairs.first_z[COORD_W-1], pairs.first_z});
    assign mx = dx[DIFF_W-1] ? $unsigned(-dx) : $unsigned(dx);
    assign my = dy[DIFF_W-1] ? $unsigned(-dy) : $unsigned(dy);
    assign mz = dz[DIFF_W-1] ? $unsigned(-dz) : $unsigned(dz);

    assign m_az = (nx1_reg > ny1_reg) ? nx1_reg : ny1_reg;
    assign m_po = (nz1_reg > m_az) ? nz1_reg : m_az;

    assign rdy5 = !v5_reg || tag_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pairs.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end
        else if (rdy1) begin
            v1_reg           <= pairs.valid;
            id1_reg.row      <= pairs.row_index;
            id1_reg.col      <= pairs.col_index;
            id1_reg.zero_out <= (pairs.row_index == pairs.col_index);
            id1_reg.vert     <= (dx == '0) && (dy == '0);
            azn1_reg         <= dx[DIFF_W-1];
            pon1_reg         <= dz[DIFF_W-1];
            nx1_reg          <= mx;
            ny1_reg          <= my;
            nz1_reg          <= mz;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v2_reg <= 1'b0;
        end
        else if (rdy2) begin
            v2_reg   <= v1_reg;
            id2_reg  <= id1_reg;
            azn2_reg <= azn1_reg;
            pon2_reg <= pon1_reg;
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;
            nz2_reg  <= nz1_reg;
            paz2_reg <= top_bit(m_az);
            ppo2_reg <= top_bit(m_po);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end
        else if (rdy3) begin
            v3_reg        <= v2_reg;
            t3_reg.id     <= id2_reg;
            t3_reg.az_neg <= azn2_reg;
            t3_reg.po_neg <= pon2_reg;
            t3_reg.az_x   <= norm_val(nx2_reg, paz2_reg);
            t3_reg.az_y   <= norm_val(ny2_reg, paz2_reg);
            t3_reg.pz     <= norm_val(nz2_reg, ppo2_reg);
            px3_reg       <= norm_val(nx2_reg, ppo2_reg);
            py3_reg       <= norm_val(ny2_reg, ppo2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v4_reg <= 1'b0;
        end
        else if (rdy4) begin
            v4_reg  <= v3_reg;
            t4_reg  <= t3_reg;
            sx4_reg <= px3_reg * px3_reg;
            sy4_reg <= py3_reg * py3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v5_reg <= 1'b0;
        end
        else if (rdy5) begin
            v5_reg   <= v4_reg;
            t5_reg   <= t4_reg;
            sum5_reg <= RAD_W'(sx4_reg) + RAD_W'(sy4_reg);
        end
    end

    assign tag_valid = v5_reg;
    assign tag       = t5_reg;
    assign sq_sum    = sum5_reg;

endmodule

// File: hw/rtl/pda_sqrt_cell.sv
// One square root cell: settles one root bit from the next two radicand bits.
module pda_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pda_pkg::pda_sqrt_t d_in,
    output logic               out_valid,
    input  logic               out_ready,
    output pda_pkg::pda_sqrt_t d_out
);
    import pda_pkg::*;

    logic      v_reg;
    pda_sqrt_t d_reg;
    pda_sqrt_t d_next;
    logic [REM_W+1:0] rem_t;
    logic [REM_W+1:0] trial;

    assign rem_t = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({d_in.root, 2'b01});

    always_comb begin
        d_next     = d_in;
        d_next.rad = {d_in.rad[RAD_W-3:0], 2'b00};
        if (rem_t >= trial) begin
            d_next.rem  = REM_W'(rem_t - trial);
            d_next.root = {d_in.root[ROOT_W-2:0], 1'b1};
        end
        else begin
            d_next.rem  = REM_W'(rem_t);
            d_next.root = {d_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end
        else if (in_ready) begin
            v_reg <= in_valid;
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign d_out     = d_reg;

endmodule

// File: hw/rtl/pda_cordic_cell.sv
// One CORDIC vectoring cell, turning the azimuth and polar vectors side by side.
module pda_cordic_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pda_pkg::STEP_W-1:0]  step,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pda_pkg::pda_cord_t          d_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pda_pkg::pda_cord_t          d_out
);
    import pda_pkg::*;

    logic      v_reg;
    pda_cord_t d_reg;

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end
        else if (in_ready) begin
            v_reg    <= in_valid;
            d_reg.id <= d_in.id;
            d_reg.az <= cordic_step(d_in.az, step);
            d_reg.po <= cordic_step(d_in.po, step);
        end
    end

    assign out_valid = v_reg;
    assign d_out     = d_reg;

endmodule

// File: hw/rtl/pairwise_direction_angles.sv
// Top level: azimuth and polar angle of the difference vector of a particle pair.
//
//  channel  dir  word contents
//  -------  ---  ------------------------------------------------------------
//  pairs    in   row_index, col_index, first_x/y/z, second_x/y/z (Q16.16)
//  angles   out  out_row, out_col, azimuth, polar (Q2.14 radians, 0..pi)
//
// One pair word per cycle sustained while angles is ready; the chain has 5 front cells,
// 31 square root cells (one root bit each), 2 polar normalize stages,
// 20 CORDIC cells (azimuth and polar together) and the output register.
// Every cell holds its own valid bit, so bubbles close up under a stall and
// pairs keeps accepting until the chain fills while a result waits on angles.
// Reset clears only the valid bits; data registers are not reset.
module pairwise_direction_angles (
    input  logic     clk,
    input  logic     rst_n,
    pda_in_if.sink   pairs,
    pda_out_if.source angles
);
    import pda_pkg::*;

    // front
    logic             f_valid;
    logic             f_ready;
    pda_tag_t         f_tag;
    logic [RAD_W-1:0] f_sum;

    // square root chain
    logic      s_valid [0:SQRT_CELLS];
    logic      s_ready [0:SQRT_CELLS];
    pda_sqrt_t s_data  [0:SQRT_CELLS];

    // polar normalize stages
    logic              p1_valid_reg;
    pda_id_t           p1_id_reg;
    pda_rot_t          p1_az_reg;
    logic              p1_neg_reg;
    logic [NORM_W-1:0] p1_pz_reg;
    logic [ROOT_W-1:0] p1_rho_reg;
    logic [POS_W-1:0]  p1_pos_reg;
    logic              p1_ready;
    logic [ROOT_W-1:0] s_max;

    logic              p2_valid_reg;
    pda_id_t           p2_id_reg;
    pda_rot_t          p2_az_reg;
    logic              p2_neg_reg;
    logic [NORM_W-1:0] p2_pzn_reg;
    logic [NORM_W-1:0] p2_rhon_reg;
    logic              p2_ready;

    // CORDIC chain
    logic      c_valid [0:CORDIC_STEPS];
    logic      c_ready [0:CORDIC_STEPS];
    pda_cord_t c_data  [0:CORDIC_STEPS];

    // output register
    logic               o_valid_reg;
    logic [IDX_W-1:0]   o_row_reg;
    logic [IDX_W-1:0]   o_col_reg;
    logic [ANGLE_W-1:0] o_az_reg;
    logic [ANGLE_W-1:0] o_po_reg;
    logic               o_ready;

    pda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pairs     (pairs),
        .tag_valid (f_valid),
        .tag_ready (f_ready),
        .tag       (f_tag),
        .sq_sum    (f_sum)
    );

    // radicand enters with empty remainder and root
    assign s_valid[0]     = f_valid;
    assign f_ready        = s_ready[0];
    assign s_data[0].tag  = f_tag;
    assign s_data[0].rem  = '0;
    assign s_data[0].root = '0;
    assign s_data[0].rad  = f_sum;

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        pda_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s_valid[k]),
            .in_ready  (s_ready[k]),
            .d_in      (s_data[k]),
            .out_valid (s_valid[k+1]),
            .out_ready (s_ready[k+1]),
            .d_out     (s_data[k+1])
        );
    end

    // rho and the normalized |dz| share one more normalization for the polar atan2
    assign s_max = (ROOT_W'(s_data[SQRT_CELLS].tag.pz) > s_data[SQRT_CELLS].root)
                 ? ROOT_W'(s_data[SQRT_CELLS].tag.pz) : s_data[SQRT_CELLS].root;

    assign p2_ready                = !p2_valid_reg || c_ready[0];
    assign p1_ready                = !p1_valid_reg || p2_ready;
    assign s_ready[SQRT_CELLS]     = p1_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p1_valid_reg <= 1'b0;
        end
        else if (p1_ready) begin
            p1_valid_reg <= s_valid[SQRT_CELLS];
            p1_id_reg    <= s_data[SQRT_CELLS].tag.id;
            p1_az_reg    <= cordic_init(s_data[SQRT_CELLS].tag.az_neg,
                                        s_data[SQRT_CELLS].tag.az_x,
                                        s_data[SQRT_CELLS].tag.az_y);
            p1_neg_reg   <= s_data[SQRT_CELLS].tag.po_neg;
            p1_pz_reg    <= s_data[SQRT_CELLS].tag.pz;
            p1_rho_reg   <= s_data[SQRT_CELLS].root;
            p1_pos_reg   <= top_bit(DIFF_W'(s_max));
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            p2_valid_reg <= 1'b0;
        end
        else if (p2_ready) begin
            p2_valid_reg <= p1_valid_reg;
            p2_id_reg    <= p1_id_reg;
            p2_az_reg    <= p1_az_reg;
            p2_neg_reg   <= p1_neg_reg;
            p2_pzn_reg   <= norm_val(DIFF_W'(p1_pz_reg), p1_pos_reg);
            p2_rhon_reg  <= norm_val(DIFF_W'(p1_rho_reg), p1_pos_reg);
        end
    end

    assign c_valid[0]   = p2_valid_reg;
    assign c_data[0].id = p2_id_reg;
    assign c_data[0].az = p2_az_reg;
    assign c_data[0].po = cordic_init(p2_neg_reg, p2_pzn_reg, p2_rhon_reg);

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        pda_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(k)),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .d_in      (c_data[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .d_out     (c_data[k+1])
        );
    end

    // equal indices win over the vertical case
    assign o_ready               = !o_valid_reg || angles.ready;
    assign c_ready[CORDIC_STEPS] = o_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready) begin
            o_valid_reg <= c_valid[CORDIC_STEPS];
            o_row_reg   <= c_data[CORDIC_STEPS].id.row;
            o_col_reg   <= c_data[CORDIC_STEPS].id.col;
            if (c_data[CORDIC_STEPS].id.zero_out) begin
                o_az_reg <= '0;
                o_po_reg <= '0;
            end
            else if (c_data[CORDIC_STEPS].id.vert) begin
                o_az_reg <= '0;
                o_po_reg <= HALF_PI_APPROX_Q14;
            end
            else begin
                o_az_reg <= angle_round(c_data[CORDIC_STEPS].az.z);
                o_po_reg <= angle_round(c_data[CORDIC_STEPS].po.z);
            end
        end
    end

    assign angles.valid   = o_valid_reg;
    assign angles.out_row = o_row_reg;
    assign angles.out_col = o_col_reg;
    assign angles.azimuth = o_az_reg;
    assign angles.polar   = o_po_reg;

    // an empty output register means the whole chain can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !angles.valid |-> pairs.ready)
        else $error("pairs stalled with an empty output register");

    // square root remainder never exceeds twice the root
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid[SQRT_CELLS] |->
            (s_data[SQRT_CELLS].rem <= REM_W'({s_data[SQRT_CELLS].root, 1'b0})))
        else $error("square root remainder out of range");

    // polar vector enters CORDIC with its larger part normalized
    a_polar_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg && !(p2_pzn_reg == '0 && p2_rhon_reg == '0)) |->
            (p2_pzn_reg[NORM_TOP] || p2_rhon_reg[NORM_TOP]))
        else $error("polar vector not normalized");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid |-> (angles.azimuth <= PI_Q14 && angles.polar <= PI_Q14))
        else $error("angle above pi");

endmodule
